// ===== rtl/core/cpbs_pkg.sv =====
package cpbs_pkg;

    // default coordinate width, signed q.8
    localparam int COORD_BITS_DEF = 24;

    // segment parameters are unsigned q1.16 in 0..65536
    localparam int FRAC_BITS = 16;
    localparam int Q_BITS    = FRAC_BITS + 1;
    localparam logic [Q_BITS-1:0] Q_ONE = Q_BITS'(1) << FRAC_BITS;

    // one quotient bit per divider stage
    localparam int DIV_STEPS = FRAC_BITS;

    localparam int PSHIFT_BITS = 6;
    localparam logic [PSHIFT_BITS-1:0] PSHIFT_RESET = PSHIFT_BITS'(23);

    typedef enum logic [2:0] {
        CASE_BOTH_PT  = 3'd0,
        CASE_U_PT     = 3'd1,
        CASE_V_PT     = 3'd2,
        CASE_PARALLEL = 3'd3,
        CASE_GENERAL  = 3'd4
    } case_code_t;

endpackage

// ===== rtl/core/closest_points_between_segments.sv =====
// closest points between two 3d segments: each input word holds segment u (ua to ub) and
// segment v (va to vb) as signed q.8 coordinates of COORD_BITS bits, and each output word
// holds the closest point of u, the closest point of v and a case code (both points, u a
// point, v a point, near parallel, general). the block is a fixed pipeline of 44 register
// stages: differences, products, dot products, half-width partial products of the wide
// products, their sums, the determinant test, four restoring dividers of one quotient bit
// per stage for s (three lanes) and for t when u is a point, then t = (b*s - f)/e through
// a fifth divider of the same kind, and finally the interpolation. one word is accepted
// every clock unless the output side stalls; a stall freezes the whole pipeline, and the
// last stage is the output register. parallel_shift is written through cfg_wr_en /
// cfg_wr_data and resets to 23; a pair is near parallel when det is zero or det <
// (a*e) >> parallel_shift.
module closest_points_between_segments #(
    parameter int COORD_BITS = cpbs_pkg::COORD_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_wr_en,
    input  logic [cpbs_pkg::PSHIFT_BITS-1:0] cfg_wr_data,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic signed [COORD_BITS-1:0] s_ua_x,
    input  logic signed [COORD_BITS-1:0] s_ua_y,
    input  logic signed [COORD_BITS-1:0] s_ua_z,
    input  logic signed [COORD_BITS-1:0] s_ub_x,
    input  logic signed [COORD_BITS-1:0] s_ub_y,
    input  logic signed [COORD_BITS-1:0] s_ub_z,
    input  logic signed [COORD_BITS-1:0] s_va_x,
    input  logic signed [COORD_BITS-1:0] s_va_y,
    input  logic signed [COORD_BITS-1:0] s_va_z,
    input  logic signed [COORD_BITS-1:0] s_vb_x,
    input  logic signed [COORD_BITS-1:0] s_vb_y,
    input  logic signed [COORD_BITS-1:0] s_vb_z,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [COORD_BITS-1:0] m_pu_x,
    output logic signed [COORD_BITS-1:0] m_pu_y,
    output logic signed [COORD_BITS-1:0] m_pu_z,
    output logic signed [COORD_BITS-1:0] m_pv_x,
    output logic signed [COORD_BITS-1:0] m_pv_y,
    output logic signed [COORD_BITS-1:0] m_pv_z,
    output logic [2:0]            m_case_code
);

    localparam int N    = COORD_BITS;
    localparam int DLW  = N + 1;                 // coordinate differences
    localparam int PRW  = 2 * N + 2;             // single products
    localparam int DW   = 2 * N + 4;             // dot products
    localparam int HW   = DW / 2;                // halves of a dot product
    localparam int PPW  = 2 * HW + 2;            // partial products
    localparam int PW   = 2 * DW;                // products of dot products
    localparam int LW   = PW + 2;                // divider lanes
    localparam int QW   = cpbs_pkg::Q_BITS;
    localparam int FB   = cpbs_pkg::FRAC_BITS;
    localparam int TNW  = DW + QW + 1;           // t numerator
    localparam int MW   = DLW + QW + 1;          // interpolation products
    localparam int NL   = 4;                     // parallel divider lanes
    localparam int DS   = cpbs_pkg::DIV_STEPS;

    // stage numbers
    localparam int ST_DIFF  = 1;
    localparam int ST_PROD  = 2;
    localparam int ST_DOT   = 3;
    localparam int ST_PART  = 4;
    localparam int ST_WIDE  = 5;
    localparam int ST_DET   = 6;
    localparam int ST_SETUP = 7;
    localparam int ST_DIV0  = ST_SETUP + 1;
    localparam int ST_TN    = ST_DIV0 + DS;
    localparam int ST_TSET  = ST_TN + 1;
    localparam int ST_TDIV0 = ST_TSET + 1;
    localparam int ST_LERP  = ST_TDIV0 + DS;
    localparam int ST_OUT   = ST_LERP + 1;
    localparam int NST      = ST_OUT + 1;

    localparam logic [MW-1:0] HALF = MW'(1) << (FB - 1);

    typedef struct packed {
        logic signed [LW-1:0] n;
        logic signed [LW-1:0] d;
        logic [QW-1:0]        q;
        logic                 fix;
    } lane_t;

    // high*high, high*low, low*high, low*low
    typedef logic [3:0][PPW-1:0] part_t;

    typedef struct packed {
        logic [2:0][N-1:0]    ua;
        logic [2:0][N-1:0]    ub;
        logic [2:0][N-1:0]    va;
        logic [2:0][N-1:0]    vb;
        logic [2:0][DLW-1:0]  du;
        logic [2:0][DLW-1:0]  dv;
        logic [2:0][DLW-1:0]  dr;
        logic [14:0][PRW-1:0] pr;
        logic signed [DW-1:0] a;
        logic signed [DW-1:0] e;
        logic signed [DW-1:0] b;
        logic signed [DW-1:0] c;
        logic signed [DW-1:0] f;
        part_t [3:0]          pp;
        logic signed [PW-1:0] ae;
        logic signed [PW-1:0] bb;
        logic signed [PW-1:0] ce;
        logic signed [PW-1:0] fb;
        logic signed [PW:0]   det;
        logic signed [PW:0]   num;
        logic signed [DW:0]   bc;
        logic signed [DW:0]   nf;
        cpbs_pkg::case_code_t code;
        lane_t [NL-1:0]       ln;
        logic signed [TNW-1:0] tn;
        logic signed [TNW-1:0] td;
        logic                 tneg;
        logic                 tgt;
        lane_t                lt;
        logic [2:0][MW-1:0]   mu;
        logic [2:0][MW-1:0]   mv;
        logic [2:0][N-1:0]    pu;
        logic [2:0][N-1:0]    pv;
    } pipe_t;

    // clamped quotient setup: 0 when n <= 0, one when n >= d, else run the steps
    function automatic lane_t div_init(logic signed [LW-1:0] n, logic signed [LW-1:0] d);
        lane_t r;
        r.n   = n;
        r.d   = d;
        r.q   = '0;
        r.fix = 1'b0;
        if (n <= 0) begin
            r.fix = 1'b1;
        end else if (n >= d) begin
            r.fix = 1'b1;
            r.q   = cpbs_pkg::Q_ONE;
        end
        return r;
    endfunction

    // one restoring division step
    function automatic lane_t div_step(lane_t l);
        lane_t r;
        logic signed [LW-1:0] n2;
        r  = l;
        n2 = l.n <<< 1;
        if (!l.fix) begin
            if (n2 >= l.d) begin
                r.n = n2 - l.d;
                r.q = {l.q[QW-2:0], 1'b1};
            end else begin
                r.n = n2;
                r.q = {l.q[QW-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    // split both operands into a signed high half and an unsigned low half
    function automatic part_t wmul_part(logic signed [DW-1:0] x, logic signed [DW-1:0] y);
        part_t r;
        logic signed [HW:0] xh;
        logic signed [HW:0] xl;
        logic signed [HW:0] yh;
        logic signed [HW:0] yl;
        xh   = $signed({x[DW-1], x[DW-1:HW]});
        xl   = $signed({1'b0, x[HW-1:0]});
        yh   = $signed({y[DW-1], y[DW-1:HW]});
        yl   = $signed({1'b0, y[HW-1:0]});
        r[0] = PPW'(xh) * PPW'(yh);
        r[1] = PPW'(xh) * PPW'(yl);
        r[2] = PPW'(xl) * PPW'(yh);
        r[3] = PPW'(xl) * PPW'(yl);
        return r;
    endfunction

    // weighted sum of the partial products
    function automatic logic signed [PW-1:0] wmul_sum(part_t pp);
        logic signed [PW-1:0] hh;
        logic signed [PW-1:0] mid;
        logic signed [PW-1:0] ll;
        hh  = PW'($signed(pp[0])) <<< (2 * HW);
        mid = (PW'($signed(pp[1])) + PW'($signed(pp[2]))) <<< HW;
        ll  = PW'($signed(pp[3]));
        return hh + mid + ll;
    endfunction

    pipe_t st_reg  [NST];
    pipe_t st_next [NST];
    logic [NST-1:0] vld_reg;
    logic [cpbs_pkg::PSHIFT_BITS-1:0] pshift_reg;
    logic adv;

    // whole pipeline moves when the output register is empty or being taken
    assign adv     = !vld_reg[ST_OUT] || m_ready;
    assign s_ready = adv;
    assign m_valid = vld_reg[ST_OUT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pshift_reg <= cpbs_pkg::PSHIFT_RESET;
        end else if (cfg_wr_en) begin
            pshift_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NST-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < NST; k++) begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    // input capture
    always_comb begin
        st_next[0]       = '0;
        st_next[0].ua[0] = s_ua_x;
        st_next[0].ua[1] = s_ua_y;
        st_next[0].ua[2] = s_ua_z;
        st_next[0].ub[0] = s_ub_x;
        st_next[0].ub[1] = s_ub_y;
        st_next[0].ub[2] = s_ub_z;
        st_next[0].va[0] = s_va_x;
        st_next[0].va[1] = s_va_y;
        st_next[0].va[2] = s_va_z;
        st_next[0].vb[0] = s_vb_x;
        st_next[0].vb[1] = s_vb_y;
        st_next[0].vb[2] = s_vb_z;
    end

    // segment directions and start offset
    always_comb begin
        st_next[ST_DIFF] = st_reg[ST_DIFF-1];
        for (int i = 0; i < 3; i++) begin
            st_next[ST_DIFF].du[i] = DLW'($signed(st_reg[ST_DIFF-1].ub[i]))
                                   - DLW'($signed(st_reg[ST_DIFF-1].ua[i]));
            st_next[ST_DIFF].dv[i] = DLW'($signed(st_reg[ST_DIFF-1].vb[i]))
                                   - DLW'($signed(st_reg[ST_DIFF-1].va[i]));
            st_next[ST_DIFF].dr[i] = DLW'($signed(st_reg[ST_DIFF-1].va[i]))
                                   - DLW'($signed(st_reg[ST_DIFF-1].ua[i]));
        end
    end

    // fifteen component products
    always_comb begin
        pipe_t p;
        p = st_reg[ST_PROD-1];
        st_next[ST_PROD] = p;
        for (int i = 0; i < 3; i++) begin
            st_next[ST_PROD].pr[i]      = PRW'($signed(p.du[i])) * PRW'($signed(p.du[i]));
            st_next[ST_PROD].pr[3 + i]  = PRW'($signed(p.dv[i])) * PRW'($signed(p.dv[i]));
            st_next[ST_PROD].pr[6 + i]  = PRW'($signed(p.du[i])) * PRW'($signed(p.dv[i]));
            st_next[ST_PROD].pr[9 + i]  = PRW'($signed(p.du[i])) * PRW'($signed(p.dr[i]));
            st_next[ST_PROD].pr[12 + i] = PRW'($signed(p.dv[i])) * PRW'($signed(p.dr[i]));
        end
    end

    // dot products a, e, b, c, f
    always_comb begin
        pipe_t p;
        p = st_reg[ST_DOT-1];
        st_next[ST_DOT]   = p;
        st_next[ST_DOT].a = DW'($signed(p.pr[0])) + DW'($signed(p.pr[1]))
                          + DW'($signed(p.pr[2]));
        st_next[ST_DOT].e = DW'($signed(p.pr[3])) + DW'($signed(p.pr[4]))
                          + DW'($signed(p.pr[5]));
        st_next[ST_DOT].b = DW'($signed(p.pr[6])) + DW'($signed(p.pr[7]))
                          + DW'($signed(p.pr[8]));
        st_next[ST_DOT].c = DW'($signed(p.pr[9])) + DW'($signed(p.pr[10]))
                          + DW'($signed(p.pr[11]));
        st_next[ST_DOT].f = DW'($signed(p.pr[12])) + DW'($signed(p.pr[13]))
                          + DW'($signed(p.pr[14]));
    end

    // partial products of a*e, b*b, c*e, f*b
    always_comb begin
        pipe_t p;
        p = st_reg[ST_PART-1];
        st_next[ST_PART]       = p;
        st_next[ST_PART].pp[0] = wmul_part(p.a, p.e);
        st_next[ST_PART].pp[1] = wmul_part(p.b, p.b);
        st_next[ST_PART].pp[2] = wmul_part(p.c, p.e);
        st_next[ST_PART].pp[3] = wmul_part(p.f, p.b);
    end

    // wide products
    always_comb begin
        pipe_t p;
        p = st_reg[ST_WIDE-1];
        st_next[ST_WIDE]    = p;
        st_next[ST_WIDE].ae = wmul_sum(p.pp[0]);
        st_next[ST_WIDE].bb = wmul_sum(p.pp[1]);
        st_next[ST_WIDE].ce = wmul_sum(p.pp[2]);
        st_next[ST_WIDE].fb = wmul_sum(p.pp[3]);
    end

    // determinant, near parallel test and case selection
    always_comb begin
        pipe_t p;
        logic [PW-1:0] thr;
        logic signed [PW:0] det;
        logic par;
        p   = st_reg[ST_DET-1];
        det = (PW+1)'(p.ae) - (PW+1)'(p.bb);
        thr = PW'(p.ae) >> pshift_reg;
        par = (det == '0) || (det < $signed({1'b0, thr}));
        st_next[ST_DET]     = p;
        st_next[ST_DET].det = det;
        st_next[ST_DET].num = (PW+1)'(p.ce) - (PW+1)'(p.fb);
        st_next[ST_DET].bc  = (DW+1)'(p.b) + (DW+1)'(p.c);
        st_next[ST_DET].nf  = -((DW+1)'(p.f));
        priority if (p.a == '0 && p.e == '0) begin
            st_next[ST_DET].code = cpbs_pkg::CASE_BOTH_PT;
        end else if (p.a == '0) begin
            st_next[ST_DET].code = cpbs_pkg::CASE_U_PT;
        end else if (p.e == '0) begin
            st_next[ST_DET].code = cpbs_pkg::CASE_V_PT;
        end else if (par) begin
            st_next[ST_DET].code = cpbs_pkg::CASE_PARALLEL;
        end else begin
            st_next[ST_DET].code = cpbs_pkg::CASE_GENERAL;
        end
    end

    // divider lanes: s, s for t clamped low, s for t clamped high, t when u is a point
    always_comb begin
        pipe_t p;
        p = st_reg[ST_SETUP-1];
        st_next[ST_SETUP] = p;
        if (p.code == cpbs_pkg::CASE_GENERAL) begin
            st_next[ST_SETUP].ln[0] = div_init(LW'(p.num), LW'(p.det));
        end else begin
            st_next[ST_SETUP].ln[0] = div_init(LW'(p.c), LW'(p.a));
        end
        st_next[ST_SETUP].ln[1] = div_init(LW'(p.c), LW'(p.a));
        st_next[ST_SETUP].ln[2] = div_init(LW'(p.bc), LW'(p.a));
        st_next[ST_SETUP].ln[3] = div_init(LW'(p.nf), LW'(p.e));
    end

    for (genvar g = 0; g < DS; g++) begin : g_div
        always_comb begin
            st_next[ST_DIV0+g] = st_reg[ST_DIV0+g-1];
            for (int l = 0; l < NL; l++) begin
                st_next[ST_DIV0+g].ln[l] = div_step(st_reg[ST_DIV0+g-1].ln[l]);
            end
        end
    end

    // t numerator from the s of lane 0, clamped to 0..1 but not yet re-picked for a clamped t
    always_comb begin
        pipe_t p;
        p = st_reg[ST_TN-1];
        st_next[ST_TN]    = p;
        st_next[ST_TN].tn = TNW'(p.b) * TNW'($signed({1'b0, p.ln[0].q}))
                          - (TNW'(p.f) <<< FB);
        st_next[ST_TN].td = TNW'(p.e) <<< FB;
    end

    always_comb begin
        pipe_t p;
        p = st_reg[ST_TSET-1];
        st_next[ST_TSET]      = p;
        st_next[ST_TSET].tneg = p.tn < 0;
        st_next[ST_TSET].tgt  = p.tn > p.td;
        st_next[ST_TSET].lt   = div_init(LW'(p.tn), LW'(p.td));
    end

    for (genvar g = 0; g < DS; g++) begin : g_tdiv
        always_comb begin
            st_next[ST_TDIV0+g]    = st_reg[ST_TDIV0+g-1];
            st_next[ST_TDIV0+g].lt = div_step(st_reg[ST_TDIV0+g-1].lt);
        end
    end

    // pick s and t for the case, then scale the directions
    always_comb begin
        pipe_t p;
        logic [QW-1:0] s;
        logic [QW-1:0] t;
        p = st_reg[ST_LERP-1];
        s = '0;
        t = '0;
        unique case (p.code)
            cpbs_pkg::CASE_BOTH_PT: begin
                s = '0;
                t = '0;
            end
            cpbs_pkg::CASE_U_PT: begin
                s = '0;
                t = p.ln[3].q;
            end
            cpbs_pkg::CASE_V_PT, cpbs_pkg::CASE_PARALLEL: begin
                s = p.ln[0].q;
                t = '0;
            end
            cpbs_pkg::CASE_GENERAL: begin
                priority if (p.tneg) begin
                    s = p.ln[1].q;
                    t = '0;
                end else if (p.tgt) begin
                    s = p.ln[2].q;
                    t = cpbs_pkg::Q_ONE;
                end else begin
                    s = p.ln[0].q;
                    t = p.lt.q;
                end
            end
            default: begin
                s = '0;
                t = '0;
            end
        endcase
        st_next[ST_LERP] = p;
        for (int i = 0; i < 3; i++) begin
            st_next[ST_LERP].mu[i] = MW'($signed(p.du[i])) * MW'($signed({1'b0, s}));
            st_next[ST_LERP].mv[i] = MW'($signed(p.dv[i])) * MW'($signed({1'b0, t}));
        end
    end

    // round half up and add the start points
    always_comb begin
        pipe_t p;
        logic signed [MW-1:0] ou;
        logic signed [MW-1:0] ov;
        p = st_reg[ST_OUT-1];
        st_next[ST_OUT] = p;
        for (int i = 0; i < 3; i++) begin
            ou = $signed(p.mu[i] + HALF) >>> FB;
            ov = $signed(p.mv[i] + HALF) >>> FB;
            st_next[ST_OUT].pu[i] = p.ua[i] + ou[N-1:0];
            st_next[ST_OUT].pv[i] = p.va[i] + ov[N-1:0];
        end
    end

    assign m_pu_x      = st_reg[ST_OUT].pu[0];
    assign m_pu_y      = st_reg[ST_OUT].pu[1];
    assign m_pu_z      = st_reg[ST_OUT].pu[2];
    assign m_pv_x      = st_reg[ST_OUT].pv[0];
    assign m_pv_y      = st_reg[ST_OUT].pv[1];
    assign m_pv_z      = st_reg[ST_OUT].pv[2];
    assign m_case_code = st_reg[ST_OUT].code;

endmodule
